// ===== rtl/nie_pkg.sv =====
// Package for the Newton interpolation engine: payload structs, status codes,
// Q16.16 arithmetic helpers. No dependencies.
package nie_pkg;

   localparam int MaxPoints = 16;
   localparam int IdxW      = $clog2(MaxPoints);
   localparam int CntW      = $clog2(MaxPoints + 1);

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_READY = 2'd1,
      ST_DUP_NODE  = 2'd2,
      ST_SATURATED = 2'd3
   } status_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   typedef struct packed {
      logic               op;
      logic signed [31:0] abscissa;
      logic signed [31:0] ordinate;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
   } rsp_type;

   // Per-cell control broadcast from the sequencer.
   typedef struct packed {
      logic            load;
      logic [IdxW-1:0] load_idx;
      logic            shift;
   } cell_ctl_type;

   typedef struct packed {
      logic signed [31:0] v;
      logic               sat;
   } satv_type;

   function automatic satv_type sat64(input logic signed [65:0] v);
      satv_type r;
      if (v > 66'sd2147483647) begin
         r.v = 32'sh7fffffff; r.sat = 1'b1;
      end else if (v < -66'sd2147483648) begin
         r.v = 32'sh80000000; r.sat = 1'b1;
      end else begin
         r.v = v[31:0]; r.sat = 1'b0;
      end
      return r;
   endfunction

   function automatic satv_type qsub(input logic signed [31:0] a,
                                     input logic signed [31:0] b);
      logic signed [65:0] d;
      d = 66'(a) - 66'(b);
      return sat64(d);
   endfunction

   // round half up then floor shift
   function automatic satv_type qround(input logic signed [63:0] p);
      logic signed [65:0] s;
      s = (66'(p) + 66'sd32768) >>> 16;
      return sat64(s);
   endfunction

endpackage

// ===== rtl/nie_cell.sv =====
// One storage cell of the node chain: holds a node, a sample and a coefficient.
// Cells shift toward index 0 each rotate step. Depends on nie_pkg.
module nie_cell
   import nie_pkg::*;
(
   input  logic               clock,
   input  logic [IdxW-1:0]    my_idx,
   input  cell_ctl_type       ctl,
   input  logic signed [31:0] load_node,
   input  logic signed [31:0] load_samp,
   input  logic               coef_we,
   input  logic signed [31:0] coef_in,
   input  logic signed [31:0] next_node,
   input  logic signed [31:0] next_samp,
   input  logic signed [31:0] next_coef,
   output logic signed [31:0] node,
   output logic signed [31:0] samp,
   output logic signed [31:0] coef
);
   logic signed [31:0] node_ff, samp_ff, coef_ff;

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         node_ff <= next_node;
         samp_ff <= next_samp;
         coef_ff <= next_coef;
      end else begin
         if (ctl.load && ctl.load_idx == my_idx) begin
            node_ff <= load_node;
            samp_ff <= load_samp;
         end
         if (coef_we) coef_ff <= coef_in;
      end
   end

   assign node = node_ff;
   assign samp = samp_ff;
   assign coef = coef_ff;
endmodule

// ===== rtl/nie_divider.sv =====
// Radix-2 restoring divider: (r * 2^16) / d, truncated toward zero, saturated.
// Depends on nie_pkg.
module nie_divider
   import nie_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic signed [31:0] quo,
   output logic               sat
);
   logic [47:0] rem_ff, rem_in;
   logic [47:0] q_ff, q_in;
   logic [47:0] n_ff;
   logic [31:0] d_ff;
   logic        neg_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [48:0] trial;
   logic signed [49:0] sq;
   satv_type    sv;

   always_comb begin
      rem_in = {rem_ff[46:0], n_ff[47]};
      trial  = {1'b0, rem_in} - {17'd0, d_ff};
      q_in   = {q_ff[46:0], ~trial[48]};
      if (!trial[48]) rem_in = trial[47:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd48;
            rem_ff  <= '0;
            q_ff    <= '0;
            n_ff    <= {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
            d_ff    <= den[31] ? 32'(-den) : 32'(den);
            neg_ff  <= num[31] ^ den[31];
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            q_ff   <= q_in;
            n_ff   <= {n_ff[46:0], 1'b0};
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0; done_ff <= 1'b1;
            end
         end
      end
   end

   always_comb begin
      sq  = neg_ff ? -$signed({2'b0, q_ff}) : $signed({2'b0, q_ff});
      sv  = sat64(66'(sq));
   end
   assign done = done_ff;
   assign quo  = sv.v;
   assign sat  = sv.sat;
endmodule

// ===== rtl/newton_interpolation_engine.sv =====
// Top level of the Newton interpolation engine: handshake, sequencer, cell
// chain, multiply-accumulate datapath. Depends on nie_pkg, nie_cell, nie_divider.
//
// Points are loaded one per transaction, with no result. The transaction
// marked last runs the solve. Row i passes through a setup state, then i steps
// (subtract and multiply, accumulate and multiply, round and rotate), a state
// to start the divide and a wait on the 48-step serial divider. Rows after
// the first also rotate the chain back into place: a turn-around state plus
// n - i shifts. A closing pass through the setup state posts the result.
// An evaluation reads the nodes in place and runs one Horner step (subtract,
// multiply, round and add, advance) per node below the top one; a single
// point posts the top coefficient directly. Not-ready and failed-solve
// replies are posted straight from the idle state. One item is handled at
// a time, and a new request is accepted only once the previous result has
// left the rsp register. The node cells' contents are undefined until
// loaded; no reset pass is needed.
module newton_interpolation_engine
   import nie_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_ROW, S_STEP_A, S_STEP_B, S_STEP_C, S_DIV_GO, S_DIV_WAIT,
      S_RALIGN, S_EV_A, S_EV_B, S_EV_C, S_EV_D, S_OUT
   } state_type;

   state_type state_ff;
   logic [CntW-1:0] count_ff;
   logic            ready_ff;
   logic [1:0]      err_ff;
   logic            sat_ff;
   logic [IdxW:0]   row_ff, step_ff;
   logic signed [31:0] basis_ff, xi_ff, yi_ff, h_ff, t_ff, d_ff;
   logic signed [63:0] prod_ff;
   logic signed [63:0] prod2_ff;
   logic signed [39:0] acc_ff;
   rsp_type         rsp_ff;
   logic            rsp_valid_ff;

   // chain
   logic signed [31:0] node_w [MaxPoints];
   logic signed [31:0] samp_w [MaxPoints];
   logic signed [31:0] coef_w [MaxPoints];
   cell_ctl_type ctl;
   logic         coef_we_any;
   logic [IdxW-1:0] coef_idx;
   logic signed [31:0] coef_wdata;
   logic [CntW-1:0] rot_len;
   logic [IdxW-1:0] last_idx;
   logic [IdxW-1:0] ev_idx;

   logic div_start, div_done, div_sat;
   logic signed [31:0] div_quo;
   satv_type sv_a, sv_b, sv_c, sv_r, sv_e, sv_h;

   // rotation spans only the loaded points: cell last_idx takes cell 0
   assign rot_len  = count_ff;
   assign last_idx = IdxW'(rot_len - CntW'(1));
   // Horner step k works on node step_ff - 1
   assign ev_idx   = IdxW'(step_ff - (IdxW+1)'(1));

   genvar g;
   generate
      for (g = 0; g < MaxPoints; g++) begin : g_cell
         logic signed [31:0] nn, ns, nc;
         logic we;
         always_comb begin
            if (IdxW'(g) == last_idx) begin
               nn = node_w[0]; ns = samp_w[0]; nc = coef_w[0];
            end else begin
               nn = node_w[(g + 1) % MaxPoints];
               ns = samp_w[(g + 1) % MaxPoints];
               nc = coef_w[(g + 1) % MaxPoints];
            end
            we = coef_we_any && coef_idx == IdxW'(g);
         end
         nie_cell u_cell (
            .clock(clock), .my_idx(IdxW'(g)), .ctl(ctl),
            .load_node(req_data.abscissa), .load_samp(req_data.ordinate),
            .coef_we(we), .coef_in(coef_wdata),
            .next_node(nn), .next_samp(ns), .next_coef(nc),
            .node(node_w[g]), .samp(samp_w[g]), .coef(coef_w[g])
         );
      end
   endgenerate

   // numerator is held stable by yi_ff/acc_ff while the divider latches it
   nie_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(sv_r.v),
      .den(basis_ff), .done(div_done), .quo(div_quo), .sat(div_sat)
   );

   logic fresh;
   assign fresh = ready_ff || (err_ff != ST_OK);
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   logic take;
   assign take = req_valid && req_ready;
   logic [CntW-1:0] eff_count;
   assign eff_count = fresh ? '0 : count_ff;

   always_comb begin
      ctl.load     = take && req_data.op == OP_LOAD && eff_count < CntW'(MaxPoints);
      ctl.load_idx = IdxW'(eff_count);
      ctl.shift    = (state_ff == S_STEP_C) || (state_ff == S_RALIGN);
      coef_we_any  = (state_ff == S_DIV_WAIT) && div_done;
      coef_idx     = '0;
      coef_wdata   = div_quo;
      div_start    = (state_ff == S_DIV_GO);
      sv_a = qsub(xi_ff, node_w[0]);
      sv_b = qround(prod_ff);
      sv_c = qround(prod2_ff);
      sv_r = sat64(66'(yi_ff) - 66'(acc_ff));
      sv_e = qsub(t_ff, node_w[ev_idx]);
      sv_h = sat64(66'(sv_b.v) + 66'(coef_w[ev_idx]));
   end

   // Solve: at the start of row i the chain is aligned so that cell 0 holds point 0;
   // row i point sits at cell i. Each step c uses cell 0 (node c,
   // coef c) then rotates. After i steps, cell 0 holds point i; the quotient is
   // written there; then the chain rotates the rest of the way back.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; ready_ff <= 1'b0; err_ff <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (take) begin
                  if (req_data.op == OP_LOAD) begin
                     if (fresh) begin
                        ready_ff <= 1'b0; err_ff <= ST_OK;
                     end
                     count_ff <= (eff_count < CntW'(MaxPoints))
                                 ? eff_count + CntW'(1) : eff_count;
                     if (req_data.last) begin
                        sat_ff <= 1'b0; row_ff <= '0;
                        state_ff <= S_ROW;
                     end
                  end else if (err_ff == ST_DUP_NODE) begin
                     rsp_ff <= '{value: '0, status: ST_DUP_NODE};
                     rsp_valid_ff <= 1'b1;
                  end else if (!ready_ff || count_ff == '0) begin
                     rsp_ff <= '{value: '0, status: ST_NOT_READY};
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     // Horner starts from the top coefficient
                     t_ff <= req_data.abscissa;
                     h_ff <= coef_w[last_idx];
                     step_ff <= (IdxW+1)'(count_ff - CntW'(1));
                     sat_ff <= (err_ff == ST_SATURATED);
                     state_ff <= (count_ff == CntW'(1)) ? S_EV_D : S_EV_A;
                  end
               end
            end
            S_ROW: begin
               if (row_ff == (IdxW+1)'(count_ff)) begin
                  ready_ff <= 1'b1;
                  err_ff   <= sat_ff ? ST_SATURATED : ST_OK;
                  rsp_ff   <= '{value: '0, status: sat_ff ? ST_SATURATED : ST_OK};
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  xi_ff    <= node_w[row_ff[IdxW-1:0]];
                  yi_ff    <= samp_w[row_ff[IdxW-1:0]];
                  basis_ff <= 32'sh00010000;
                  acc_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= (row_ff == '0) ? S_DIV_GO : S_STEP_A;
               end
            end
            S_STEP_A: begin
               prod_ff  <= 64'(basis_ff) * 64'(coef_w[0]);
               d_ff     <= sv_a.v;
               sat_ff   <= sat_ff | sv_a.sat;
               state_ff <= S_STEP_B;
            end
            S_STEP_B: begin
               acc_ff   <= acc_ff + 40'(sv_b.v);
               sat_ff   <= sat_ff | sv_b.sat;
               prod2_ff <= 64'(basis_ff) * 64'(d_ff);
               state_ff <= S_STEP_C;
            end
            S_STEP_C: begin
               basis_ff <= sv_c.v;
               sat_ff   <= sat_ff | sv_c.sat;
               step_ff  <= step_ff + 1'b1;
               state_ff <= (step_ff + 1'b1 == row_ff) ? S_DIV_GO : S_STEP_A;
            end
            S_DIV_GO: begin
               if (basis_ff == '0) begin
                  err_ff <= ST_DUP_NODE; ready_ff <= 1'b0;
                  rsp_ff <= '{value: '0, status: ST_DUP_NODE};
                  rsp_valid_ff <= 1'b1;
                  // restore chain alignment
                  step_ff  <= (IdxW+1)'(count_ff) - row_ff;
                  state_ff <= (row_ff == '0) ? S_IDLE : S_OUT;
               end else begin
                  sat_ff     <= sat_ff | sv_r.sat;
                  state_ff   <= S_DIV_WAIT;
               end
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  sat_ff <= sat_ff | div_sat;
                  step_ff <= (row_ff == '0) ? '0 : (IdxW+1)'(count_ff) - row_ff;
                  row_ff <= row_ff + 1'b1;
                  state_ff <= (row_ff == '0) ? S_ROW : S_OUT;
               end
            end
            S_OUT: begin
               // finish rotation back to alignment (shift asserted via RALIGN)
               state_ff <= S_RALIGN;
            end
            S_RALIGN: begin
               step_ff <= step_ff - 1'b1;
               if (step_ff <= (IdxW+1)'(1)) begin
                  state_ff <= (err_ff == ST_DUP_NODE) ? S_IDLE : S_ROW;
               end
            end
            S_EV_A: begin
               d_ff     <= sv_e.v;
               sat_ff   <= sat_ff | sv_e.sat;
               state_ff <= S_EV_B;
            end
            S_EV_B: begin
               prod_ff  <= 64'(h_ff) * 64'(d_ff);
               state_ff <= S_EV_C;
            end
            S_EV_C: begin
               h_ff     <= sv_h.v;
               sat_ff   <= sat_ff | sv_b.sat | sv_h.sat;
               state_ff <= S_EV_D;
            end
            S_EV_D: begin
               // step down to the next lower node
               step_ff <= step_ff - 1'b1;
               if (step_ff <= (IdxW+1)'(1)) begin
                  rsp_ff <= '{value: h_ff, status: sat_ff ? ST_SATURATED : ST_OK};
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else state_ff <= S_EV_A;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxPoints)) else $error("point count overflow");
endmodule
